/* hdl/keypad_debounce_long_short_press_assert.svh */
// Assertion helpers shared by the keypad debounce blocks.
// Each macro expects signals named clock and reset in the using module.
`ifndef KEYPAD_DEBOUNCE_LONG_SHORT_PRESS_ASSERT_SVH
`define KEYPAD_DEBOUNCE_LONG_SHORT_PRESS_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define KPD_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("keypad debounce check failed");

// Same-cycle implication.
`define KPD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keypad debounce check failed");

// Next-cycle implication.
`define KPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad debounce check failed");

`endif

/* hdl/kpd_pkg.sv */
package kpd_pkg;

   // Board table size
   localparam int NUM_BOARDS  = 8;
   localparam int BOARD_IDX_W = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

   // Key codes
   localparam logic [3:0] KEY_NONE = 4'd15;

   // Priority map, indexed [bit][row], row 0 = a, 1 = b, 2 = c
   localparam logic [3:0] KEY_MAP [4][3] = '{
      '{4'd1,  4'd2, 4'd3},
      '{4'd4,  4'd5, 4'd6},
      '{4'd7,  4'd8, 4'd9},
      '{4'd10, 4'd0, 4'd11}
   };

   // Register indexes on the csr port
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_LONG     = 2'd1;
   localparam logic [1:0] CSR_SHORT    = 2'd2;

   // Reset values of the thresholds
   localparam logic [15:0] DEBOUNCE_RST = 16'd20;
   localparam logic [15:0] LONG_RST     = 16'd1000;
   localparam logic [15:0] SHORT_RST    = 16'd500;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Classified scan passed from front to back
   typedef struct packed {
      logic [2:0]  board;
      logic [3:0]  key;
      logic [31:0] now_ms;
   } cmd_type;

   // Threshold registers
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] short_press_ms;
   } cfg_type;

   // Queue handshake between modules
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hdl/kpd_front.sv */
module kpd_front import kpd_pkg::*; (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  qstat_type   q_stat,
   output logic        push,
   output cmd_type     cmd
);

   logic [3:0] row_a;
   logic [3:0] row_b;
   logic [3:0] row_c;
   logic [3:0] key;

   assign row_a = req_tdata[6:3];
   assign row_b = req_tdata[10:7];
   assign row_c = req_tdata[14:11];

   // Fixed-priority encoder: lowest bit first, then row a, b, c
   always_comb begin
      key = KEY_NONE;
      for (int b = 3; b >= 0; b--) begin
         if (row_c[b]) key = KEY_MAP[b][2];
         if (row_b[b]) key = KEY_MAP[b][1];
         if (row_a[b]) key = KEY_MAP[b][0];
      end
   end

   // Request enters the queue whenever there is room
   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

   assign cmd.board  = req_tdata[2:0];
   assign cmd.key    = key;
   assign cmd.now_ms = req_tdata[46:15];

endmodule

/* hdl/kpd_queue.sv */
module kpd_queue import kpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   pop_cmd,
   output qstat_type stat
);

`include "keypad_debounce_long_short_press_assert.svh"

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   `KPD_ASSERT_ALWAYS(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `KPD_ASSERT_IMPL(a_no_pop_empty, pop, !stat.empty)
   `KPD_ASSERT_IMPL(a_no_push_full, push, !stat.full)

endmodule

/* hdl/kpd_back.sv */
module kpd_back import kpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  qstat_type   q_stat,
   input  cmd_type     cmd,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);

`include "keypad_debounce_long_short_press_assert.svh"

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DEBOUNCE,
      PH_HOLD
   } phase_type;

   // Per-board state
   phase_type   phase_ff    [NUM_BOARDS];
   logic [31:0] start_ff    [NUM_BOARDS];
   logic [3:0]  held_key_ff [NUM_BOARDS];
   logic        reported_ff [NUM_BOARDS];

   // Result register
   logic        out_valid_ff;
   logic [2:0]  board_out_ff, board_out_in;
   logic        event_ff, event_in;
   logic [3:0]  key_out_ff, key_out_in;
   logic        long_ff, long_in;
   logic        short_ff, short_in;

   // Next values of the selected entry
   phase_type   phase_in;
   logic [31:0] start_in;
   logic [3:0]  held_key_in;
   logic        reported_in;

   logic [BOARD_IDX_W-1:0] idx;
   logic                   in_range;
   logic [31:0]            elapsed;
   phase_type              cur_phase;
   logic [3:0]             cur_key;

   // Take the next request once the result slot is free or draining
   assign pop      = !q_stat.empty && (!out_valid_ff || rsp_tready);
   assign idx      = BOARD_IDX_W'(cmd.board);
   assign in_range = (32'(cmd.board) < NUM_BOARDS);
   assign cur_phase = phase_ff[idx];
   assign cur_key   = held_key_ff[idx];
   assign elapsed   = cmd.now_ms - start_ff[idx];

   // Per-board phase machine
   always_comb begin
      phase_in     = cur_phase;
      start_in     = start_ff[idx];
      held_key_in  = cur_key;
      reported_in  = reported_ff[idx];
      board_out_in = cmd.board;
      event_in     = 1'b0;
      key_out_in   = KEY_NONE;
      long_in      = 1'b0;
      short_in     = 1'b0;
      if (in_range) begin
         case (cur_phase)
            PH_DEBOUNCE: begin
               if (elapsed > {16'd0, cfg.debounce_ms}) begin
                  phase_in = (cmd.key == cur_key) ? PH_HOLD : PH_IDLE;
               end
            end
            PH_HOLD: begin
               if (cmd.key == KEY_NONE) begin
                  if (!reported_ff[idx]) begin
                     event_in    = 1'b1;
                     key_out_in  = cur_key;
                     long_in     = (elapsed >= {16'd0, cfg.long_press_ms});
                     short_in    = (elapsed <= {16'd0, cfg.short_press_ms});
                     reported_in = 1'b1;
                  end
                  phase_in    = PH_IDLE;
                  held_key_in = KEY_NONE;
               end
            end
            default: begin
               if (cmd.key != KEY_NONE) begin
                  start_in    = cmd.now_ms;
                  phase_in    = PH_DEBOUNCE;
                  held_key_in = cmd.key;
                  reported_in = 1'b0;
               end
            end
         endcase
      end
   end

   // State table and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BOARDS; i++) begin
            phase_ff[i]    <= PH_IDLE;
            held_key_ff[i] <= KEY_NONE;
            reported_ff[i] <= 1'b0;
            start_ff[i]    <= '0;
         end
      end else begin
         if (pop && in_range) begin
            phase_ff[idx]    <= phase_in;
            start_ff[idx]    <= start_in;
            held_key_ff[idx] <= held_key_in;
            reported_ff[idx] <= reported_in;
         end
         if (pop) begin
            out_valid_ff <= 1'b1;
            board_out_ff <= board_out_in;
            event_ff     <= event_in;
            key_out_ff   <= key_out_in;
            long_ff      <= long_in;
            short_ff     <= short_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, short_ff, long_ff, key_out_ff, event_ff, board_out_ff};

   `KPD_ASSERT_IMPL(a_pop_slot_free, pop, !out_valid_ff || rsp_tready)
   `KPD_ASSERT_IMPL(a_quiet_no_event, out_valid_ff && !event_ff,
      key_out_ff == KEY_NONE && !long_ff && !short_ff)
   `KPD_ASSERT_NEXT(a_release_reported, pop && event_in, reported_ff[$past(idx)])

endmodule

/* hdl/keypad_debounce_long_short_press.sv */
// Keypad debounce with long/short press detection. One scan request is taken
// per clock cycle while the queue has room, with no stall of its own; each
// request gives exactly one response. A request passes through the queue into the
// result register, which drives rsp_tvalid, once that register is free. The
// rate is set by the per-board read-modify-write of the phase table in the
// back stage, one board entry per cycle; a two-entry queue between the encoder
// and that stage absorbs response-side stalls. The user must write thresholds
// on the csr port only while no request is in flight; the block does not check.
// req_tdata: board[2:0], row_a[6:3], row_b[10:7], row_c[14:11], now_ms[46:15].
// rsp_tdata: board_out[2:0], event_valid[3], key_code[7:4], long_press[8],
// short_press[9].
module keypad_debounce_long_short_press import kpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Scan requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // board, row_a_bits, row_b_bits, row_c_bits, now_ms
   // Press events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // board_out, event_valid, key_code, long_press, short_press
   // Threshold registers
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg_ff;
   qstat_type q_stat;
   cmd_type   push_cmd;
   cmd_type   pop_cmd;
   logic      push;
   logic      pop;

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RST;
         cfg_ff.long_press_ms  <= LONG_RST;
         cfg_ff.short_press_ms <= SHORT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ms    <= csr_wdata;
            CSR_LONG:     cfg_ff.long_press_ms  <= csr_wdata;
            CSR_SHORT:    cfg_ff.short_press_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   kpd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .cmd        (push_cmd)
   );

   kpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   kpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import kpd_pkg::*;

   // Per-board machine phases as kept by the scoreboard
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DEBOUNCE,
      PH_HOLD
   } board_phase_type;

   // Index beyond the last threshold register, written to prove it is ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  board;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [3:0]  rc;
      logic [31:0] now_ms;
   } scan_type;

   typedef struct packed {
      logic [2:0] board;
      logic       event_valid;
      logic [3:0] key_code;
      logic       long_press;
      logic       short_press;
   } press_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_DEBOUNCE;
   logic [15:0] csr_wdata = '0;

   keypad_debounce_long_short_press u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Scoreboard copy of the thresholds and the per-board table
   logic [15:0]     cfg_debounce = DEBOUNCE_RST;
   logic [15:0]     cfg_long     = LONG_RST;
   logic [15:0]     cfg_short    = SHORT_RST;
   board_phase_type kp_phase    [NUM_BOARDS];
   logic [31:0]     kp_start    [NUM_BOARDS];
   logic [3:0]      kp_key      [NUM_BOARDS];
   logic            kp_reported [NUM_BOARDS];

   press_event_type pending_events [$];
   logic [31:0]     board_clock_ms [NUM_BOARDS];
   int              errors = 0;
   int              n_scans = 0;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;

   // Fixed-priority key encoder: bit 0 of rows a, b, c first, then bit 1, ...
   function automatic logic [3:0] scan_key(scan_type s);
      for (int i = 0; i < 4; i++) begin
         if (s.ra[i]) return KEY_MAP[i][0];
         if (s.rb[i]) return KEY_MAP[i][1];
         if (s.rc[i]) return KEY_MAP[i][2];
      end
      return KEY_NONE;
   endfunction

   // Advance the board table by one scan and return the press event it gives
   function automatic press_event_type predict_press(scan_type s);
      press_event_type r;
      logic [3:0]      k;
      logic [31:0]     held_ms;
      int              b;
      r.board       = s.board;
      r.event_valid = 1'b0;
      r.key_code    = KEY_NONE;
      r.long_press  = 1'b0;
      r.short_press = 1'b0;
      k = scan_key(s);
      b = s.board;
      held_ms = s.now_ms - kp_start[b];
      case (kp_phase[b])
         PH_DEBOUNCE: begin
            if (held_ms > {16'd0, cfg_debounce})
               kp_phase[b] = (k == kp_key[b]) ? PH_HOLD : PH_IDLE;
         end
         PH_HOLD: begin
            if (k == KEY_NONE) begin
               if (!kp_reported[b]) begin
                  r.event_valid  = 1'b1;
                  r.key_code     = kp_key[b];
                  r.long_press   = (held_ms >= {16'd0, cfg_long});
                  r.short_press  = (held_ms <= {16'd0, cfg_short});
                  kp_reported[b] = 1'b1;
               end
               kp_phase[b] = PH_IDLE;
               kp_key[b]   = KEY_NONE;
            end
         end
         default: begin
            // idle, and the unused phase code behaves the same
            if (k != KEY_NONE) begin
               kp_start[b]    = s.now_ms;
               kp_phase[b]    = PH_DEBOUNCE;
               kp_key[b]      = k;
               kp_reported[b] = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   // Key bits laid out as index = bit * 3 + row (row 0 = a, 1 = b, 2 = c)
   function automatic scan_type scan_of(logic [2:0] board, logic [11:0] keys,
                                        logic [31:0] now_ms);
      scan_type s;
      s.board  = board;
      s.now_ms = now_ms;
      for (int i = 0; i < 4; i++) begin
         s.ra[i] = keys[i * 3];
         s.rb[i] = keys[i * 3 + 1];
         s.rc[i] = keys[i * 3 + 2];
      end
      return s;
   endfunction

   // Key bits that encode to the given code, with random lower-priority bits
   function automatic logic [11:0] keys_for(logic [3:0] code);
      logic [11:0] keys;
      int          pos;
      keys = '0;
      pos  = 12;
      for (int q = 0; q < 12; q++)
         if (KEY_MAP[q / 3][q % 3] == code) pos = q;
      if (pos < 12) begin
         keys[pos] = 1'b1;
         for (int q = pos + 1; q < 12; q++) keys[q] = 1'($urandom_range(1));
      end
      return keys;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Response side stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // Compare each response with the oldest predicted event
   always @(posedge clock) begin
      press_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_events.pop_front();
            check_field("board_out", want.board, rsp_tdata[2:0]);
            check_field("event_valid", want.event_valid, rsp_tdata[3]);
            check_field("key_code", want.key_code, rsp_tdata[7:4]);
            check_field("long_press", want.long_press, rsp_tdata[8]);
            check_field("short_press", want.short_press, rsp_tdata[9]);
         end
      end
   end

   // Send one scan request, with a random idle gap ahead of it
   task automatic send_scan(scan_type s);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {1'b0, s.now_ms, s.rc, s.rb, s.ra, s.board};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_events.push_back(predict_press(s));
      n_scans++;
   endtask

   // Stop sending and wait for every predicted event to come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE: cfg_debounce = value;
         CSR_LONG:     cfg_long     = value;
         CSR_SHORT:    cfg_short    = value;
         default:      ;
      endcase
   endtask

   // Occasional scan on any board between the steps of a press
   task automatic maybe_noise();
      logic [2:0]  nb;
      logic [11:0] keys;
      if ($urandom_range(99) < 12) begin
         nb = 3'($urandom_range(7));
         board_clock_ms[nb] += $urandom_range(5000);
         keys = ($urandom_range(1) != 0) ? 12'($urandom_range(4095)) : 12'd0;
         send_scan(scan_of(nb, keys, board_clock_ms[nb]));
      end
   endtask

   // Press, bounce, confirm, hold and release on one board
   task automatic press_sequence(logic [2:0] b);
      logic [3:0]  k;
      logic [31:0] t0;
      logic [31:0] dur;
      logic [31:0] so_far;
      logic [11:0] keys;
      int          n;
      k  = 4'($urandom_range(11));
      t0 = board_clock_ms[b] + $urandom_range(1, 3000);
      send_scan(scan_of(b, keys_for(k), t0));
      // bounce inside the debounce window
      n = $urandom_range(3);
      repeat (n) begin
         maybe_noise();
         send_scan(scan_of(b, 12'($urandom_range(4095)),
                           t0 + $urandom_range(0, cfg_debounce)));
      end
      maybe_noise();
      // first scan past the window, mostly the same key
      board_clock_ms[b] = t0 + cfg_debounce + 1 + $urandom_range(3);
      keys = ($urandom_range(99) < 85) ? keys_for(k) : keys_for(4'($urandom_range(15)));
      send_scan(scan_of(b, keys, board_clock_ms[b]));
      // held, possibly with other keys joining
      n = $urandom_range(4);
      repeat (n) begin
         maybe_noise();
         board_clock_ms[b] += $urandom_range(200);
         send_scan(scan_of(b, keys_for(4'($urandom_range(11))), board_clock_ms[b]));
      end
      // release near one of the thresholds, or at a random later time
      so_far = board_clock_ms[b] - t0;
      case ($urandom_range(7))
         0: dur = {16'd0, cfg_short} - 32'd1;
         1: dur = {16'd0, cfg_short};
         2: dur = {16'd0, cfg_short} + 32'd1;
         3: dur = {16'd0, cfg_long} - 32'd1;
         4: dur = {16'd0, cfg_long};
         5: dur = {16'd0, cfg_long} + 32'd1;
         default: dur = so_far + $urandom_range(70000);
      endcase
      if (dur < so_far) dur = so_far + $urandom_range(2);
      board_clock_ms[b] = t0 + dur;
      send_scan(scan_of(b, 12'd0, board_clock_ms[b]));
      if ($urandom_range(99) < 30) begin
         board_clock_ms[b] += $urandom_range(50);
         send_scan(scan_of(b, 12'd0, board_clock_ms[b]));
      end
   endtask

   // Reset thresholds: short, long and neither releases, debounce boundary
   task automatic test_press_release();
      req_idle_pct  = 33;
      rsp_stall_pct = 33;
      // all keys down encodes to key 1; confirm across the timestamp wrap
      send_scan(scan_of(3'd1, 12'hFFF, 32'hFFFF_FFF0));
      send_scan(scan_of(3'd1, 12'h001, 32'h0000_0005));
      send_scan(scan_of(3'd1, 12'h000, 32'hFFFF_FFF0 + 32'd500));
      // long press of key 0
      send_scan(scan_of(3'd2, 12'h400, 32'd100));
      send_scan(scan_of(3'd2, 12'h400, 32'd121));
      send_scan(scan_of(3'd2, 12'h000, 32'd1100));
      // hold between thresholds, both flags clear
      send_scan(scan_of(3'd0, 12'h800, 32'd0));
      send_scan(scan_of(3'd0, 12'h800, 32'd21));
      send_scan(scan_of(3'd0, 12'h000, 32'd700));
      // still debouncing at the interval, other key just past it
      send_scan(scan_of(3'd7, 12'h100, 32'd50));
      send_scan(scan_of(3'd7, 12'h100, 32'd70));
      send_scan(scan_of(3'd7, 12'h004, 32'd71));
      send_scan(scan_of(3'd7, 12'h000, 32'd72));
      wait_drained();
   endtask

   // Threshold registers at their extremes, plus an unused index
   task automatic test_threshold_regs();
      write_csr(CSR_DEBOUNCE, 16'd0);
      write_csr(CSR_LONG, 16'd0);
      write_csr(CSR_SHORT, 16'hFFFF);
      write_csr(CSR_UNUSED, 16'h1234);
      send_scan(scan_of(3'd5, 12'h008, 32'hFFFF_FFFF));
      send_scan(scan_of(3'd5, 12'h008, 32'd0));
      send_scan(scan_of(3'd5, 12'h000, 32'd0));
      wait_drained();
      write_csr(CSR_DEBOUNCE, 16'hFFFF);
      write_csr(CSR_LONG, 16'hFFFF);
      write_csr(CSR_SHORT, 16'd0);
      send_scan(scan_of(3'd6, 12'h040, 32'd1000));
      send_scan(scan_of(3'd6, 12'h040, 32'd1000 + 32'd65535));
      send_scan(scan_of(3'd6, 12'h040, 32'd1000 + 32'd65536));
      send_scan(scan_of(3'd6, 12'h000, 32'd1000 + 32'd65536));
      wait_drained();
   endtask

   // One random phase with its own thresholds and idle rates
   task automatic run_phase(int idle_pct, int stall_pct, int count,
                            logic [15:0] deb, logic [15:0] lng, logic [15:0] sht);
      int target;
      wait_drained();
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_LONG, lng);
      write_csr(CSR_SHORT, sht);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int b = 0; b < NUM_BOARDS; b++) board_clock_ms[b] = $urandom;
      target = n_scans + count;
      while (n_scans < target) begin
         maybe_noise();
         press_sequence(3'($urandom_range(7)));
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 400, DEBOUNCE_RST, LONG_RST, SHORT_RST);
      run_phase(79, 0, 400, 16'($urandom_range(100)), 16'($urandom), 16'($urandom));
      run_phase(0, 79, 400, 16'd0, 16'hFFFF, 16'd0);
      run_phase(33, 33, 430, 16'hFFFF, 16'($urandom), 16'hFFFF);
   endtask

   initial begin
      for (int b = 0; b < NUM_BOARDS; b++) begin
         kp_phase[b]       = PH_IDLE;
         kp_start[b]       = '0;
         kp_key[b]         = KEY_NONE;
         kp_reported[b]    = 1'b0;
         board_clock_ms[b] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_press_release();
      test_threshold_regs();
      test_random_traffic();
      wait_drained();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
